@@ rtl/crossing_angle_lorentz_boost_unit_assert.svh @@
// ---------------------------------------------------------------------------
// crossing angle lorentz boost unit assertion macros
// shared property forms, clocked on clk and disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef CROSSING_ANGLE_LORENTZ_BOOST_UNIT_ASSERT_SVH
`define CROSSING_ANGLE_LORENTZ_BOOST_UNIT_ASSERT_SVH

// consequent must hold in the same cycle
`define CALB_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent must hold in the next cycle
`define CALB_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/calb_pkg.sv @@
// ---------------------------------------------------------------------------
// calb_pkg
// widths, constants and payload types of the x-axis lorentz boost unit
// ---------------------------------------------------------------------------
package calb_pkg;

    // data window and field widths
    localparam int DATA_WIDTH = 32;
    localparam int SAT_W      = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
    localparam int FIELD_W    = 32;
    localparam int MASS_W     = 31;
    localparam int GAMMA_W    = 18;
    localparam int BG_W       = 19;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = BG_W;
    localparam logic [CFG_IDX_W-1:0] CFG_GAMMA      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA_GAMMA = 1'b1;
    localparam logic [GAMMA_W-1:0]   GAMMA_RESET    = 18'd65536;

    // speed of light in q.16 and its inverse in q.32
    localparam int C_W     = 25;
    localparam int INVC_W  = 24;
    localparam logic [C_W-1:0]    C_Q16     = 25'd19647199;
    localparam logic [INVC_W-1:0] INV_C_Q32 = 24'd14326469;

    localparam int FRAC_SH    = 16;
    localparam int ROUND_HALF = 32768;
    localparam int SPLIT      = 20;

    // internal widths
    localparam int GX_W  = 51;
    localparam int CTF_W = 57;
    localparam int XCF_W = 56;
    localparam int CT_W  = CTF_W - FRAC_SH;
    localparam int XC_W  = XCF_W - FRAC_SH;
    localparam int PP_W  = 40;
    localparam int BX_W  = 60;
    localparam int BXC_W = 60;
    localparam int BT_W  = 52;
    localparam int BP_W  = 53;
    localparam int SQ_W  = 63;
    localparam int E2_W  = 64;
    localparam int SAT_IN_W = 64;

    // square root chain
    localparam int ROOT_W     = 32;
    localparam int ROOT_STEPS = E2_W / 2;
    localparam int REM_W      = 34;
    localparam int TRY_W      = REM_W + 2;

    // saturation rails
    localparam logic signed [SAT_IN_W-1:0] SAT_HI =
        (64'sd1 <<< (SAT_W - 1)) - 64'sd1;
    localparam logic signed [SAT_IN_W-1:0] SAT_LO = -SAT_HI - 64'sd1;
    localparam logic [FIELD_W-1:0] RAIL_HI = SAT_HI[FIELD_W-1:0];
    localparam logic [FIELD_W-1:0] RAIL_LO = SAT_LO[FIELD_W-1:0];

    // fields that ride along unchanged
    typedef struct packed {
        logic                      op;
        logic signed [FIELD_W-1:0] y;
        logic signed [FIELD_W-1:0] z;
        logic signed [FIELD_W-1:0] py;
        logic signed [FIELD_W-1:0] pz;
    } calb_pass_t;

    // boosted terms carried beside the root chain
    typedef struct packed {
        calb_pass_t               pass;
        logic signed [BX_W-1:0]   bx;
        logic signed [BT_W-1:0]   bt;
        logic signed [GX_W-1:0]   gp;
    } calb_side_t;

    // square root working state of one cell
    typedef struct packed {
        logic [E2_W-1:0]   n;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } calb_root_t;

endpackage

@@ rtl/calb_item_if.sv @@
// ---------------------------------------------------------------------------
// calb_item_if
// input channel: one vertex or particle per transaction
// ---------------------------------------------------------------------------
interface calb_item_if;
    import calb_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      op;
    logic signed [FIELD_W-1:0] pos_x;
    logic signed [FIELD_W-1:0] pos_y;
    logic signed [FIELD_W-1:0] pos_z;
    logic signed [FIELD_W-1:0] time_ns;
    logic signed [FIELD_W-1:0] mom_x;
    logic signed [FIELD_W-1:0] mom_y;
    logic signed [FIELD_W-1:0] mom_z;
    logic [MASS_W-1:0]         mass;

    modport source (
        output valid, op, pos_x, pos_y, pos_z, time_ns, mom_x, mom_y, mom_z, mass,
        input  ready
    );

    modport sink (
        input  valid, op, pos_x, pos_y, pos_z, time_ns, mom_x, mom_y, mom_z, mass,
        output ready
    );
endinterface

@@ rtl/calb_result_if.sv @@
// ---------------------------------------------------------------------------
// calb_result_if
// output channel: one boosted result per transaction
// ---------------------------------------------------------------------------
interface calb_result_if;
    import calb_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] out_x;
    logic signed [FIELD_W-1:0] out_y;
    logic signed [FIELD_W-1:0] out_z;
    logic signed [FIELD_W-1:0] out_time;
    logic signed [FIELD_W-1:0] out_mom_x;
    logic signed [FIELD_W-1:0] out_mom_y;
    logic signed [FIELD_W-1:0] out_mom_z;
    logic                      saturated;

    modport source (
        output valid, out_x, out_y, out_z, out_time, out_mom_x, out_mom_y, out_mom_z,
               saturated,
        input  ready
    );

    modport sink (
        input  valid, out_x, out_y, out_z, out_time, out_mom_x, out_mom_y, out_mom_z,
               saturated,
        output ready
    );
endinterface

@@ rtl/crossing_angle_lorentz_boost_unit.sv @@
// ---------------------------------------------------------------------------
// crossing_angle_lorentz_boost_unit
// lorentz boost along x of vertices and particles, with saturating outputs
// ---------------------------------------------------------------------------
// Takes one vertex or particle per clock and returns one result per clock
// while the output is not stalled. The pipeline has 3 front stages (products,
// partial products, boosted x and t plus the momentum square sum), 32 square
// root cells that each settle one bit of the energy, and 2 back stages (energy
// product, then rounding and saturation into the output register). Each
// stage holds only when its successor is full and stalled, so bubbles
// close up and input keeps flowing while a result waits on the output.
// gamma and beta_gamma must be written through the configuration port only
// while no transaction is in flight; the block itself does not enforce this.
`include "crossing_angle_lorentz_boost_unit_assert.svh"

module crossing_angle_lorentz_boost_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [calb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [calb_pkg::CFG_DATA_W-1:0]    cfg_data,
    calb_item_if.sink                          item,
    calb_result_if.source                      result
);
    import calb_pkg::*;

    logic [GAMMA_W-1:0]     gamma_reg, gamma_next;
    logic signed [BG_W-1:0] beta_gamma_reg, beta_gamma_next;

    logic       link_valid [ROOT_STEPS+1];
    logic       link_ready [ROOT_STEPS+1];
    calb_side_t link_side  [ROOT_STEPS+1];
    calb_root_t link_root  [ROOT_STEPS+1];

    always_comb
    begin
        gamma_next      = gamma_reg;
        beta_gamma_next = beta_gamma_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GAMMA:      gamma_next      = cfg_data[GAMMA_W-1:0];
                CFG_BETA_GAMMA: beta_gamma_next = $signed(cfg_data[BG_W-1:0]);
                default:        gamma_next      = gamma_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_reg      <= GAMMA_RESET;
            beta_gamma_reg <= '0;
        end
        else
        begin
            gamma_reg      <= gamma_next;
            beta_gamma_reg <= beta_gamma_next;
        end
    end

    calb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .gamma      (gamma_reg),
        .beta_gamma (beta_gamma_reg),
        .item       (item),
        .valid      (link_valid[0]),
        .side       (link_side[0]),
        .root       (link_root[0]),
        .down_ready (link_ready[0])
    );

    for (genvar k = 0; k < ROOT_STEPS; k++)
    begin : g_cell
        calb_sqrt_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (link_valid[k]),
            .up_side    (link_side[k]),
            .up_root    (link_root[k]),
            .up_ready   (link_ready[k]),
            .valid      (link_valid[k+1]),
            .side       (link_side[k+1]),
            .root       (link_root[k+1]),
            .down_ready (link_ready[k+1])
        );
    end

    calb_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .beta_gamma (beta_gamma_reg),
        .up_valid   (link_valid[ROOT_STEPS]),
        .up_side    (link_side[ROOT_STEPS]),
        .up_root    (link_root[ROOT_STEPS]),
        .up_ready   (link_ready[ROOT_STEPS]),
        .result     (result)
    );

    // a transaction handed from the front must land in the first cell
    `CALB_ASSERT_NXT(a_chain_entry, link_valid[0] && link_ready[0], link_valid[1], "front transaction lost at root chain entry")

    // a clipped result leaves at least one field on a rail
    `CALB_ASSERT_IMP(a_clip_on_rail, result.valid && result.saturated, result.out_x == RAIL_HI || result.out_x == RAIL_LO || result.out_time == RAIL_HI || result.out_time == RAIL_LO || result.out_y == RAIL_HI || result.out_y == RAIL_LO || result.out_z == RAIL_HI || result.out_z == RAIL_LO || result.out_mom_x == RAIL_HI || result.out_mom_x == RAIL_LO || result.out_mom_y == RAIL_HI || result.out_mom_y == RAIL_LO || result.out_mom_z == RAIL_HI || result.out_mom_z == RAIL_LO, "saturated flag without a field on a rail")

endmodule

@@ rtl/calb_front.sv @@
// ---------------------------------------------------------------------------
// calb_front
// three stage front end: products, partial products, boosted x and t, p^2 sum
// ---------------------------------------------------------------------------
module calb_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [calb_pkg::GAMMA_W-1:0]       gamma,
    input  logic signed [calb_pkg::BG_W-1:0]   beta_gamma,
    calb_item_if.sink                          item,
    output logic                               valid,
    output calb_pkg::calb_side_t               side,
    output calb_pkg::calb_root_t               root,
    input  logic                               down_ready
);
    import calb_pkg::*;

    logic v1_reg, v2_reg, v3_reg;
    logic r1, r2, r3;

    // stage 1
    calb_pass_t              pass1_reg;
    logic signed [GX_W-1:0]  gx_reg, gt_reg, gp1_reg;
    logic signed [CTF_W-1:0] ctf_reg;
    logic signed [XCF_W-1:0] xcf_reg;
    logic [SQ_W-1:0]         sq_reg [4];
    logic signed [GX_W-1:0]  gx_next, gt_next, gp1_next;
    logic signed [CTF_W-1:0] ctf_next;
    logic signed [XCF_W-1:0] xcf_next;
    logic [SQ_W-1:0]         sq_next [4];
    logic [FIELD_W-1:0]      mag [4];

    // stage 2
    calb_pass_t              pass2_reg;
    logic signed [GX_W-1:0]  gx2_reg, gt2_reg, gp2_reg;
    logic signed [PP_W-1:0]  pc_lo_reg, pc_hi_reg, px_lo_reg, px_hi_reg;
    logic [E2_W-1:0]         s01_reg, s23_reg;
    logic signed [PP_W-1:0]  pc_lo_next, pc_hi_next, px_lo_next, px_hi_next;
    logic [E2_W-1:0]         s01_next, s23_next;
    logic signed [CT_W-1:0]  ct;
    logic signed [XC_W-1:0]  xc;

    // stage 3
    calb_side_t              side_reg;
    logic [E2_W-1:0]         e2_reg;
    logic signed [BX_W-1:0]  bx_next;
    logic signed [BXC_W-1:0] bxc;
    logic signed [BT_W-1:0]  bt_next;
    logic [E2_W-1:0]         e2_next;

    assign r3 = !v3_reg || down_ready;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;
    assign item.ready = r1;

    // magnitudes for the energy squares, mass is already unsigned
    always_comb
    begin
        mag[0] = item.mom_x[FIELD_W-1] ? -item.mom_x : item.mom_x;
        mag[1] = item.mom_y[FIELD_W-1] ? -item.mom_y : item.mom_y;
        mag[2] = item.mom_z[FIELD_W-1] ? -item.mom_z : item.mom_z;
        mag[3] = FIELD_W'(item.mass);
        for (int i = 0; i < 4; i++)
        begin
            sq_next[i] = SQ_W'(E2_W'(mag[i]) * E2_W'(mag[i]));
        end
    end

    assign gx_next  = GX_W'($signed({1'b0, gamma})) * GX_W'(item.pos_x);
    assign gt_next  = GX_W'($signed({1'b0, gamma})) * GX_W'(item.time_ns);
    assign gp1_next = GX_W'($signed({1'b0, gamma})) * GX_W'(item.mom_x);
    assign ctf_next = CTF_W'($signed({1'b0, C_Q16})) * CTF_W'(item.time_ns);
    assign xcf_next = XCF_W'($signed({1'b0, INV_C_Q32})) * XCF_W'(item.pos_x);

    // floor shift by 16, then split for the beta_gamma products
    assign ct = $signed(ctf_reg[CTF_W-1:FRAC_SH]);
    assign xc = $signed(xcf_reg[XCF_W-1:FRAC_SH]);

    assign pc_lo_next = PP_W'(beta_gamma) * PP_W'($signed({1'b0, ct[SPLIT-1:0]}));
    assign pc_hi_next = PP_W'(beta_gamma) * PP_W'($signed(ct[CT_W-1:SPLIT]));
    assign px_lo_next = PP_W'(beta_gamma) * PP_W'($signed({1'b0, xc[SPLIT-1:0]}));
    assign px_hi_next = PP_W'(beta_gamma) * PP_W'($signed(xc[XC_W-1:SPLIT]));
    assign s01_next   = E2_W'(sq_reg[0]) + E2_W'(sq_reg[1]);
    assign s23_next   = E2_W'(sq_reg[2]) + E2_W'(sq_reg[3]);

    assign bx_next = BX_W'(gx2_reg) + (BX_W'(pc_hi_reg) <<< SPLIT) + BX_W'(pc_lo_reg);
    assign bxc     = (BXC_W'(px_hi_reg) <<< SPLIT) + BXC_W'(px_lo_reg);
    assign bt_next = BT_W'(gt2_reg) + BT_W'(bxc >>> FRAC_SH);
    assign e2_next = s01_reg + s23_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (r1)
            begin
                v1_reg <= item.valid;
            end
            if (r2)
            begin
                v2_reg <= v1_reg;
            end
            if (r3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && r1)
        begin
            pass1_reg.op <= item.op;
            pass1_reg.y  <= item.pos_y;
            pass1_reg.z  <= item.pos_z;
            pass1_reg.py <= item.mom_y;
            pass1_reg.pz <= item.mom_z;
            gx_reg       <= gx_next;
            gt_reg       <= gt_next;
            gp1_reg      <= gp1_next;
            ctf_reg      <= ctf_next;
            xcf_reg      <= xcf_next;
            sq_reg       <= sq_next;
        end
        if (v1_reg && r2)
        begin
            pass2_reg <= pass1_reg;
            gx2_reg   <= gx_reg;
            gt2_reg   <= gt_reg;
            gp2_reg   <= gp1_reg;
            pc_lo_reg <= pc_lo_next;
            pc_hi_reg <= pc_hi_next;
            px_lo_reg <= px_lo_next;
            px_hi_reg <= px_hi_next;
            s01_reg   <= s01_next;
            s23_reg   <= s23_next;
        end
        if (v2_reg && r3)
        begin
            side_reg.pass <= pass2_reg;
            side_reg.bx   <= bx_next;
            side_reg.bt   <= bt_next;
            side_reg.gp   <= gp2_reg;
            e2_reg        <= e2_next;
        end
    end

    assign valid     = v3_reg;
    assign side      = side_reg;
    assign root.n    = e2_reg;
    assign root.rem  = '0;
    assign root.root = '0;

endmodule

@@ rtl/calb_sqrt_cell.sv @@
// ---------------------------------------------------------------------------
// calb_sqrt_cell
// one digit of the restoring integer square root, one result bit per cell
// ---------------------------------------------------------------------------
module calb_sqrt_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 up_valid,
    input  calb_pkg::calb_side_t up_side,
    input  calb_pkg::calb_root_t up_root,
    output logic                 up_ready,
    output logic                 valid,
    output calb_pkg::calb_side_t side,
    output calb_pkg::calb_root_t root,
    input  logic                 down_ready
);
    import calb_pkg::*;

    logic       valid_reg;
    calb_side_t side_reg;
    calb_root_t root_reg;
    calb_root_t root_next;
    logic [TRY_W-1:0] r_sh;
    logic [TRY_W-1:0] trial;
    logic [TRY_W-1:0] diff;
    logic             fits;

    assign up_ready = !valid_reg || down_ready;

    // bring down the next two bits and try (4q + 1)
    always_comb
    begin
        r_sh  = {up_root.rem, up_root.n[E2_W-1 -: 2]};
        trial = {{(TRY_W-ROOT_W-2){1'b0}}, up_root.root, 2'b01};
        diff  = r_sh - trial;
        fits  = (r_sh >= trial);
        root_next.n    = {up_root.n[E2_W-3:0], 2'b00};
        root_next.rem  = fits ? diff[REM_W-1:0] : r_sh[REM_W-1:0];
        root_next.root = {up_root.root[ROOT_W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && up_ready)
        begin
            side_reg <= up_side;
            root_reg <= root_next;
        end
    end

    assign valid = valid_reg;
    assign side  = side_reg;
    assign root  = root_reg;

endmodule

@@ rtl/calb_back.sv @@
// ---------------------------------------------------------------------------
// calb_back
// energy product, momentum sum, rounding, saturation and the output register
// ---------------------------------------------------------------------------
module calb_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic signed [calb_pkg::BG_W-1:0] beta_gamma,
    input  logic                             up_valid,
    input  calb_pkg::calb_side_t             up_side,
    input  calb_pkg::calb_root_t             up_root,
    output logic                             up_ready,
    calb_result_if.source                    result
);
    import calb_pkg::*;

    function automatic logic [FIELD_W:0] clip(input logic signed [SAT_IN_W-1:0] v);
        logic [FIELD_W:0] r;
        if (v > SAT_HI)
        begin
            r = {1'b1, RAIL_HI};
        end
        else if (v < SAT_LO)
        begin
            r = {1'b1, RAIL_LO};
        end
        else
        begin
            r = {1'b0, v[FIELD_W-1:0]};
        end
        return r;
    endfunction

    logic v1_reg, v2_reg;
    logic r1, r2;

    calb_side_t             side1_reg;
    logic signed [BP_W-1:0] pe_reg;
    logic signed [BP_W-1:0] pe_next;

    logic signed [BX_W-1:0] vx;
    logic signed [BT_W-1:0] vt;
    logic signed [BP_W-1:0] vp;
    logic [FIELD_W:0]       cx, cy, cz, ct, cpx, cpy, cpz;
    logic                   sat_next;

    logic [FIELD_W-1:0] x_reg, y_reg, z_reg, t_reg, px_reg, py_reg, pz_reg;
    logic               sat_reg;

    assign r2 = !v2_reg || result.ready;
    assign r1 = !v1_reg || r2;
    assign up_ready = r1;

    assign pe_next = BP_W'(beta_gamma) * BP_W'($signed({1'b0, up_root.root}));

    // round half up, then clamp to the data window
    always_comb
    begin
        vx  = (side1_reg.bx + BX_W'(ROUND_HALF)) >>> FRAC_SH;
        vt  = (side1_reg.bt + BT_W'(ROUND_HALF)) >>> FRAC_SH;
        vp  = (BP_W'(side1_reg.gp) + pe_reg + BP_W'(ROUND_HALF)) >>> FRAC_SH;
        cx  = clip(SAT_IN_W'(vx));
        cy  = clip(SAT_IN_W'(side1_reg.pass.y));
        cz  = clip(SAT_IN_W'(side1_reg.pass.z));
        ct  = clip(SAT_IN_W'(vt));
        cpx = clip(SAT_IN_W'(vp));
        cpy = clip(SAT_IN_W'(side1_reg.pass.py));
        cpz = clip(SAT_IN_W'(side1_reg.pass.pz));
        sat_next = cx[FIELD_W] | cy[FIELD_W] | cz[FIELD_W] | ct[FIELD_W]
                 | (side1_reg.pass.op & (cpx[FIELD_W] | cpy[FIELD_W] | cpz[FIELD_W]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (r1)
            begin
                v1_reg <= up_valid;
            end
            if (r2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_valid && r1)
        begin
            side1_reg <= up_side;
            pe_reg    <= pe_next;
        end
        if (v1_reg && r2)
        begin
            x_reg   <= cx[FIELD_W-1:0];
            y_reg   <= cy[FIELD_W-1:0];
            z_reg   <= cz[FIELD_W-1:0];
            t_reg   <= ct[FIELD_W-1:0];
            // vertex transactions carry no momentum
            px_reg  <= side1_reg.pass.op ? cpx[FIELD_W-1:0] : '0;
            py_reg  <= side1_reg.pass.op ? cpy[FIELD_W-1:0] : '0;
            pz_reg  <= side1_reg.pass.op ? cpz[FIELD_W-1:0] : '0;
            sat_reg <= sat_next;
        end
    end

    assign result.valid     = v2_reg;
    assign result.out_x     = x_reg;
    assign result.out_y     = y_reg;
    assign result.out_z     = z_reg;
    assign result.out_time  = t_reg;
    assign result.out_mom_x = px_reg;
    assign result.out_mom_y = py_reg;
    assign result.out_mom_z = pz_reg;
    assign result.saturated = sat_reg;

endmodule

@@ bench/crossing_angle_lorentz_boost_unit_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// crossing_angle_lorentz_boost_unit_tb
// self-checking bench for the x-axis lorentz boost unit: corner and random
// vertices and particles under several gamma / beta-gamma settings, with
// every result predicted in fixed point and compared field by field
// ---------------------------------------------------------------------------
module crossing_angle_lorentz_boost_unit_tb;
    import calb_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 12;
    localparam int PHASES       = 9;
    localparam int RANDOM_ITEMS = 215;
    localparam int PIPE_DEPTH   = 37;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 200;
    localparam int IDLE_PCT     = 12;
    localparam int PRINT_CAP    = 40;

    localparam logic [FIELD_W-1:0] WORD_MAX = 32'h7fff_ffff;
    localparam logic [FIELD_W-1:0] WORD_MIN = 32'h8000_0000;
    localparam logic [FIELD_W-1:0] ONE_Q12  = 32'd4096;
    localparam logic [MASS_W-1:0]  MASS_MAX = '1;

    typedef enum logic {
        OP_VERTEX   = 1'b0,
        OP_PARTICLE = 1'b1
    } item_kind_e;

    typedef struct {
        item_kind_e                op;
        logic signed [FIELD_W-1:0] pos_x, pos_y, pos_z, time_ns;
        logic signed [FIELD_W-1:0] mom_x, mom_y, mom_z;
        logic [MASS_W-1:0]         mass;
    } boost_item_t;

    typedef struct {
        logic signed [FIELD_W-1:0] x, y, z, t, px, py, pz;
        logic                      saturated;
    } boost_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    bit                    steady;

    calb_item_if   item_bus ();
    calb_result_if result_bus ();

    crossing_angle_lorentz_boost_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .item      (item_bus),
        .result    (result_bus)
    );

    // ---------------------------------------------------------------------
    // fixed-point boost predictor
    // ---------------------------------------------------------------------
    function automatic logic [FIELD_W-1:0] clip_to_window(longint v, inout bit clipped);
        if (v > SAT_HI)
        begin
            v = SAT_HI;
            clipped = 1'b1;
        end
        else if (v < SAT_LO)
        begin
            v = SAT_LO;
            clipped = 1'b1;
        end
        return v[FIELD_W-1:0];
    endfunction

    // q.28 down to q.12, half rounds up
    function automatic longint round_q16(longint v);
        return (v + ROUND_HALF) >>> FRAC_SH;
    endfunction

    function automatic longint unsigned mag_squared(longint v);
        longint unsigned m;
        m = (v < 0) ? -v : v;
        return m * m;
    endfunction

    function automatic longint unsigned floor_root(longint unsigned n);
        longint unsigned root;
        longint unsigned probe;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > n)
            probe >>= 2;
        while (probe != 0)
        begin
            if (n >= root + probe)
            begin
                n    = n - (root + probe);
                root = (root >> 1) + probe;
            end
            else
                root >>= 1;
            probe >>= 2;
        end
        return root;
    endfunction

    function automatic boost_result_t lorentz_boost(boost_item_t it,
                                                    logic [GAMMA_W-1:0] g_reg,
                                                    logic signed [BG_W-1:0] bg_reg);
        longint          g, bg, c_q16, inv_c, x, t, ct, xc, px, energy;
        longint unsigned e2;
        bit              clipped;
        boost_result_t   r;
        g       = g_reg;
        bg      = bg_reg;
        c_q16   = C_Q16;
        inv_c   = INV_C_Q32;
        clipped = 1'b0;
        x       = it.pos_x;
        t       = it.time_ns;
        ct      = (t * c_q16) >>> FRAC_SH;
        xc      = (x * inv_c) >>> FRAC_SH;
        r.x = clip_to_window(round_q16(g * x + bg * ct), clipped);
        r.y = clip_to_window(it.pos_y, clipped);
        r.z = clip_to_window(it.pos_z, clipped);
        r.t = clip_to_window(round_q16(g * t + ((bg * xc) >>> FRAC_SH)), clipped);
        if (it.op == OP_PARTICLE)
        begin
            px     = it.mom_x;
            e2     = mag_squared(px) + mag_squared(it.mom_y) + mag_squared(it.mom_z)
                   + mag_squared(it.mass);
            energy = floor_root(e2);
            r.px = clip_to_window(round_q16(bg * energy + g * px), clipped);
            r.py = clip_to_window(it.mom_y, clipped);
            r.pz = clip_to_window(it.mom_z, clipped);
        end
        else
        begin
            r.px = '0;
            r.py = '0;
            r.pz = '0;
        end
        r.saturated = clipped;
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // expected boosts, in order of acceptance
    // ---------------------------------------------------------------------
    class boost_scoreboard;
        boost_result_t          pending[$];
        logic [GAMMA_W-1:0]     gamma_reg;
        logic signed [BG_W-1:0] bg_reg;
        int unsigned            mismatches, items, particles, clipped, settings;

        function new();
            gamma_reg  = GAMMA_RESET;
            bg_reg     = '0;
            mismatches = 0;
            items      = 0;
            particles  = 0;
            clipped    = 0;
            settings   = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            if (index == CFG_GAMMA)
                gamma_reg = data[GAMMA_W-1:0];
            else if (index == CFG_BETA_GAMMA)
                bg_reg = data;
        endfunction

        function void note_item(boost_item_t it);
            boost_result_t want;
            want = lorentz_boost(it, gamma_reg, bg_reg);
            pending.push_back(want);
            items++;
            if (it.op == OP_PARTICLE)
                particles++;
            if (want.saturated)
                clipped++;
        endfunction

        task report(string what);
            mismatches++;
            if (mismatches <= PRINT_CAP)
                $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_field(string name, logic [FIELD_W-1:0] got, logic [FIELD_W-1:0] want);
            if (got !== want)
                report($sformatf("%s got %h expected %h", name, got, want));
        endtask

        task check_result(boost_result_t got);
            boost_result_t want;
            if (pending.size() == 0)
            begin
                report("result with no transaction outstanding");
                return;
            end
            want = pending.pop_front();
            check_field("out_x", got.x, want.x);
            check_field("out_y", got.y, want.y);
            check_field("out_z", got.z, want.z);
            check_field("out_time", got.t, want.t);
            check_field("out_mom_x", got.px, want.px);
            check_field("out_mom_y", got.py, want.py);
            check_field("out_mom_z", got.pz, want.pz);
            check_field("saturated", got.saturated, want.saturated);
        endtask
    endclass

    boost_scoreboard book;

    // ---------------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------------
    function automatic logic [FIELD_W-1:0] random_word();
        logic [FIELD_W-1:0] w;
        w = $urandom();
        case ($urandom_range(0, 9))
            0:       w = WORD_MIN;
            1:       w = WORD_MAX;
            2, 3, 4: ;
            5:       w = {{24{w[7]}}, w[7:0]};
            default: w = {{9{w[22]}}, w[22:0]};
        endcase
        return w;
    endfunction

    function automatic boost_item_t random_item();
        boost_item_t it;
        it.op      = ($urandom_range(0, 1) == 1) ? OP_PARTICLE : OP_VERTEX;
        it.pos_x   = random_word();
        it.pos_y   = random_word();
        it.pos_z   = random_word();
        it.time_ns = random_word();
        it.mom_x   = random_word();
        it.mom_y   = random_word();
        it.mom_z   = random_word();
        it.mass    = MASS_W'(random_word());
        return it;
    endfunction

    function automatic boost_item_t make_item(item_kind_e op,
                                              logic [FIELD_W-1:0] x, y, z, t,
                                              logic [FIELD_W-1:0] px, py, pz,
                                              logic [MASS_W-1:0] m);
        boost_item_t it;
        it.op      = op;
        it.pos_x   = x;
        it.pos_y   = y;
        it.pos_z   = z;
        it.time_ns = t;
        it.mom_x   = px;
        it.mom_y   = py;
        it.mom_z   = pz;
        it.mass    = m;
        return it;
    endfunction

    task automatic send_item(boost_item_t it);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT)
        begin
            item_bus.valid <= 1'b0;
            @(posedge clk);
        end
        item_bus.valid   <= 1'b1;
        item_bus.op      <= it.op;
        item_bus.pos_x   <= it.pos_x;
        item_bus.pos_y   <= it.pos_y;
        item_bus.pos_z   <= it.pos_z;
        item_bus.time_ns <= it.time_ns;
        item_bus.mom_x   <= it.mom_x;
        item_bus.mom_y   <= it.mom_y;
        item_bus.mom_z   <= it.mom_z;
        item_bus.mass    <= it.mass;
        @(posedge clk);
        while (item_bus.ready !== 1'b1)
            @(posedge clk);
        book.note_item(it);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        book.write_reg(index, data);
        @(posedge clk);
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain_results();
        item_bus.valid <= 1'b0;
        while (book.pending.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic corner_items();
        send_item(make_item(OP_VERTEX, '0, '0, '0, '0, '0, '0, '0, '0));
        send_item(make_item(OP_PARTICLE, '0, '0, '0, '0, '0, '0, '0, '0));
        send_item(make_item(OP_PARTICLE, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX,
                            WORD_MAX, WORD_MAX, WORD_MAX, MASS_MAX));
        send_item(make_item(OP_PARTICLE, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN,
                            WORD_MIN, WORD_MIN, WORD_MIN, '0));
        // vertex ignores momentum and mass
        send_item(make_item(OP_VERTEX, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX,
                            WORD_MIN, WORD_MIN, WORD_MIN, MASS_MAX));
        send_item(make_item(OP_VERTEX, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN,
                            WORD_MAX, WORD_MAX, WORD_MAX, '0));
        // largest energy square sum
        send_item(make_item(OP_PARTICLE, '0, '0, '0, '0,
                            WORD_MIN, WORD_MIN, WORD_MIN, MASS_MAX));
        // particle at rest
        send_item(make_item(OP_PARTICLE, ONE_Q12, '0, '0, ONE_Q12, '0, '0, '0, ONE_Q12));
        send_item(make_item(OP_VERTEX, 32'd1, '1, 32'd1, '1, '0, '0, '0, '0));
        send_item(make_item(OP_PARTICLE, -ONE_Q12, '0, '0, '0, '1, '0, '0, '0));
        send_item(make_item(OP_PARTICLE, WORD_MAX, '0, '0, WORD_MIN, WORD_MAX, '0, '0, '0));
        send_item(make_item(OP_VERTEX, WORD_MIN, '0, '0, WORD_MAX, '0, '0, '0, '0));
    endtask

    // ---------------------------------------------------------------------
    // clock, result sink and watchdog
    // ---------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    initial
    begin : result_sink
        int unsigned   hold_left;
        int unsigned   seen;
        boost_result_t got;
        hold_left = 0;
        seen      = 0;
        result_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && result_bus.valid === 1'b1 && result_bus.ready === 1'b1)
            begin
                got.x         = result_bus.out_x;
                got.y         = result_bus.out_y;
                got.z         = result_bus.out_z;
                got.t         = result_bus.out_time;
                got.px        = result_bus.out_mom_x;
                got.py        = result_bus.out_mom_y;
                got.pz        = result_bus.out_mom_z;
                got.saturated = result_bus.saturated;
                book.check_result(got);
                seen++;
                // long back-pressure so the pipeline fills and stalls its input
                if (seen == HOLD_AT)
                    hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                result_bus.ready <= 1'b0;
            end
            else
                result_bus.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((item_bus.valid === 1'b1 && item_bus.ready === 1'b1) ||
                (result_bus.valid === 1'b1 && result_bus.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("** crossing_angle_lorentz_boost_unit: FAILED **");
        $finish;
    end

    // ---------------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------------
    initial
    begin : stimulus
        int unsigned phase;
        book = new();
        steady = 1'b0;
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= CFG_GAMMA;
        cfg_data         <= '0;
        item_bus.valid   <= 1'b0;
        item_bus.op      <= OP_VERTEX;
        item_bus.pos_x   <= '0;
        item_bus.pos_y   <= '0;
        item_bus.pos_z   <= '0;
        item_bus.time_ns <= '0;
        item_bus.mom_x   <= '0;
        item_bus.mom_y   <= '0;
        item_bus.mom_z   <= '0;
        item_bus.mass    <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: ; // reset values: identity boost
                1:
                begin
                    write_reg(CFG_GAMMA, CFG_DATA_W'(18'h3ffff));
                    write_reg(CFG_BETA_GAMMA, 19'h3ffff);
                end
                2:
                begin
                    write_reg(CFG_GAMMA, CFG_DATA_W'(GAMMA_RESET));
                    write_reg(CFG_BETA_GAMMA, 19'h40000);
                end
                3:
                begin
                    // gamma below 1.0 is still taken as given
                    write_reg(CFG_GAMMA, '0);
                    write_reg(CFG_BETA_GAMMA, '1);
                end
                4:
                begin
                    write_reg(CFG_BETA_GAMMA, '0);
                    write_reg(CFG_GAMMA, CFG_DATA_W'(GAMMA_RESET));
                end
                5, 6, 7:
                begin
                    write_reg(CFG_GAMMA, CFG_DATA_W'($urandom_range(65536, 262143)));
                    write_reg(CFG_BETA_GAMMA, CFG_DATA_W'($urandom()));
                end
                default:
                begin
                    write_reg(CFG_GAMMA, CFG_DATA_W'($urandom()));
                    write_reg(CFG_BETA_GAMMA, CFG_DATA_W'($urandom()));
                end
            endcase
            book.settings++;
            steady = (phase == 2);
            if (phase < 2)
                corner_items();
            repeat (RANDOM_ITEMS) send_item(random_item());
            drain_results();
        end

        steady = 1'b0;
        repeat (PIPE_DEPTH + 8) @(posedge clk);
        if (book.pending.size() != 0)
            book.report($sformatf("%0d results never arrived", book.pending.size()));

        $display("boost coverage: %0d transactions (%0d particles) over %0d register settings",
                 book.items, book.particles, book.settings);
        $display("boost coverage: %0d results clipped, %0d mismatches",
                 book.clipped, book.mismatches);
        if (book.mismatches == 0)
            $display("** crossing_angle_lorentz_boost_unit: PASSED **");
        else
            $display("** crossing_angle_lorentz_boost_unit: FAILED **");
        $finish;
    end

endmodule
